FILE: rtl/core/affine_texture_sampler_macros.svh
// assertion helpers for the texture sampler checker
`ifndef AFFINE_TEXTURE_SAMPLER_MACROS_SVH
`define AFFINE_TEXTURE_SAMPLER_MACROS_SVH

// same-cycle implication, quiet during reset
`define ATS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("texture sampler check failed");

// next-cycle implication, quiet during reset
`define ATS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("texture sampler check failed");

// next-cycle implication that also holds across reset
`define ATS_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("texture sampler check failed");

`endif

FILE: rtl/core/ats_pkg.sv
`default_nettype none
package ats_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_SPAN   = 64;

  localparam int SIZE_W  = 9;
  localparam int PER_W   = 10;
  localparam int COORD_W = 32;
  localparam int UV_W    = 50;

  localparam logic [2:0] REG_COEF_A  = 3'd0;
  localparam logic [2:0] REG_COEF_B  = 3'd1;
  localparam logic [2:0] REG_COEF_C  = 3'd2;
  localparam logic [2:0] REG_COEF_D  = 3'd3;
  localparam logic [2:0] REG_COEF_E  = 3'd4;
  localparam logic [2:0] REG_COEF_F  = 3'd5;
  localparam logic [2:0] REG_TILE    = 3'd6;
  localparam logic [2:0] REG_SIZE    = 3'd7;

  localparam logic [1:0] MODE_CLAMP  = 2'd0;
  localparam logic [1:0] MODE_REPEAT = 2'd1;
  localparam logic [1:0] MODE_MIRROR = 2'd2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_SPAN  = 1'b1;

endpackage
`default_nettype wire

FILE: rtl/core/ats_remainder.sv
`default_nettype none
module ats_remainder (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [31:0]               magnitude,
  input  logic [ats_pkg::PER_W-1:0] period,
  output logic                      done,
  output logic [ats_pkg::PER_W-1:0] rem
);
  import ats_pkg::*;

  localparam int BITS_PER_CYCLE = 8;
  localparam int CHUNKS = 32 / BITS_PER_CYCLE;
  localparam int CNT_W = $clog2(CHUNKS);

  logic [31:0]      dvd;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [31:0]      dvd_next;
  logic [PER_W-1:0] rem_next;
  logic [PER_W:0]   trial;

  always_comb begin
    dvd_next = dvd;
    rem_next = rem;
    trial = '0;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      trial = {rem_next, dvd_next[31]};
      dvd_next = {dvd_next[30:0], 1'b0};
      if (trial >= {1'b0, period}) begin
        trial = trial - {1'b0, period};
      end
      rem_next = trial[PER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd  <= magnitude;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        dvd <= dvd_next;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(CHUNKS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/affine_texture_sampler.sv
// channel  | handshake             | payload
// in       | in_valid / in_ready   | func, pos_x, pos_y, span_length, texel_value
// out      | out_valid / out_ready | pixel_value, last_in_span
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// a texel write goes straight into the texture memory; a span first sums four
// products on one shared multiplier, then yields each pixel through the
// coordinate state, the tiling remainder units and the registered memory read.
// rst is synchronous; the texture memory is not cleared.
// a stalled output holds the next pixel back; in_ready is low during a span.
`default_nettype none
module affine_texture_sampler #(
  parameter int MAX_WIDTH  = ats_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ats_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_SPAN   = ats_pkg::DEF_MAX_SPAN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  input  logic [6:0]  span_length,
  input  logic [31:0] texel_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pixel_value,
  output logic        last_in_span,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ats_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_COORD = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_TILE  = 3'd4;
  localparam logic [2:0] ST_LOAD  = 3'd5;

  logic [31:0] coef_a, coef_b, coef_c, coef_d, coef_e, coef_f;
  logic [1:0]  tile_mode;
  logic [15:0] bitmap_size;

  logic [2:0]  state;
  logic [2:0]  mstep;
  logic [11:0] span_x, span_y;
  logic [6:0]  remaining;
  logic signed [UV_W-1:0] u, v;
  logic signed [61:0] prod;
  logic [31:0] cx, cy;
  logic [31:0] rd_data;
  logic [31:0] mem [DEPTH];

  logic signed [31:0] mul_a;
  logic signed [29:0] mul_p;
  logic signed [UV_W-1:0] pf;
  logic [31:0] fx, fy, magx, magy;
  logic [SIZE_W-1:0] w, h;
  logic [PER_W-1:0] perx, pery, remx, remy;
  logic done_x, done_y;
  logic [SIZE_W-1:0] tx, ty;
  logic [6:0] len_clip;
  logic wr_en;
  logic [AW-1:0] waddr, raddr;

  function automatic logic [SIZE_W-1:0] tile_fix(input logic [1:0] mode,
                                                  input logic [31:0] c,
                                                  input logic [PER_W-1:0] r,
                                                  input logic [SIZE_W-1:0] sz);
    logic [PER_W-1:0] per;
    logic [PER_W-1:0] m;
    logic [SIZE_W-1:0] res;
    per = (mode == MODE_MIRROR) ? {sz, 1'b0} : {1'b0, sz};
    m = r;
    if (c[31] && (r != '0)) begin
      m = per - r;
    end
    if (mode == MODE_MIRROR && m >= {1'b0, sz}) begin
      m = per - 1'b1 - m;
    end
    res = m[SIZE_W-1:0];
    if (mode != MODE_REPEAT && mode != MODE_MIRROR) begin
      if (c[31]) begin
        res = '0;
      end else if (c >= {{(32-SIZE_W){1'b0}}, sz}) begin
        res = sz - 1'b1;
      end else begin
        res = c[SIZE_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] sat_floor(input logic [UV_W-1:0] q);
    logic [31:0] res;
    if (!q[UV_W-1] && (q[UV_W-2:47] != '0)) begin
      res = 32'h7fff_ffff;
    end else if (q[UV_W-1] && (q[UV_W-2:47] != '1)) begin
      res = 32'h8000_0000;
    end else begin
      res = q[47:16];
    end
    return res;
  endfunction

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    w = SIZE_W'(bitmap_size[7:0]) + 1'b1;
    h = SIZE_W'(bitmap_size[15:8]) + 1'b1;
    if (32'(w) > MAX_WIDTH) begin
      w = SIZE_W'(MAX_WIDTH);
    end
    if (32'(h) > MAX_HEIGHT) begin
      h = SIZE_W'(MAX_HEIGHT);
    end
  end

  assign perx = (tile_mode == MODE_MIRROR) ? {w, 1'b0} : {1'b0, w};
  assign pery = (tile_mode == MODE_MIRROR) ? {h, 1'b0} : {1'b0, h};

  always_comb begin
    case (mstep)
      3'd0: mul_a = coef_a;
      3'd1: mul_a = coef_c;
      3'd2: mul_a = coef_b;
      default: mul_a = coef_d;
    endcase
  end

  assign mul_p = mstep[0] ? $signed({2'b00, span_y, 16'h8000})
                          : $signed({2'b00, span_x, 16'h8000});
  assign pf = {{(UV_W-46){prod[61]}}, prod[61:16]};

  assign fx   = sat_floor(u);
  assign fy   = sat_floor(v);
  assign magx = fx[31] ? (~fx + 1'b1) : fx;
  assign magy = fy[31] ? (~fy + 1'b1) : fy;

  ats_remainder u_rem_x (
    .clk(clk), .rst(rst), .start(state == ST_COORD), .magnitude(magx),
    .period(perx), .done(done_x), .rem(remx)
  );

  ats_remainder u_rem_y (
    .clk(clk), .rst(rst), .start(state == ST_COORD), .magnitude(magy),
    .period(pery), .done(done_y), .rem(remy)
  );

  assign tx = tile_fix(tile_mode, cx, remx, w);
  assign ty = tile_fix(tile_mode, cy, remy, h);
  assign raddr = AW'(32'(ty) * MAX_WIDTH) + AW'(tx);
  assign waddr = AW'(32'(pos_y) * MAX_WIDTH + 32'(pos_x));
  assign wr_en = in_valid && in_ready && (func == FUNC_WRITE) &&
                 (32'(pos_x) < MAX_WIDTH) && (32'(pos_y) < MAX_HEIGHT);
  assign len_clip = (32'(span_length) > MAX_SPAN) ? 7'(MAX_SPAN) : span_length;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= texel_value;
    end
    if (state == ST_TILE) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= 32'h0001_0000;
      coef_b <= '0;
      coef_c <= '0;
      coef_d <= 32'h0001_0000;
      coef_e <= '0;
      coef_f <= '0;
      tile_mode <= MODE_CLAMP;
      bitmap_size <= 16'hffff;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COEF_A: coef_a <= cfg_data;
        REG_COEF_B: coef_b <= cfg_data;
        REG_COEF_C: coef_c <= cfg_data;
        REG_COEF_D: coef_d <= cfg_data;
        REG_COEF_E: coef_e <= cfg_data;
        REG_COEF_F: coef_f <= cfg_data;
        REG_TILE:   tile_mode <= cfg_data[1:0];
        REG_SIZE:   bitmap_size <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      mstep <= '0;
      remaining <= '0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid && func == FUNC_SPAN && len_clip != '0) begin
            span_x <= pos_x;
            span_y <= pos_y;
            remaining <= len_clip;
            u <= {{(UV_W-32){coef_e[31]}}, coef_e};
            v <= {{(UV_W-32){coef_f[31]}}, coef_f};
            mstep <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mstep != 3'd4) begin
            prod <= mul_a * mul_p;
          end
          if (mstep == 3'd1 || mstep == 3'd2) begin
            u <= u + pf;
          end else if (mstep != 3'd0) begin
            v <= v + pf;
          end
          mstep <= mstep + 1'b1;
          if (mstep == 3'd4) begin
            state <= ST_COORD;
          end
        end
        ST_COORD: begin
          cx <= fx;
          cy <= fy;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (done_x && done_y) begin
            state <= ST_TILE;
          end
        end
        ST_TILE: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            pixel_value <= rd_data;
            last_in_span <= (remaining == 7'd1);
            remaining <= remaining - 1'b1;
            u <= u + {{(UV_W-32){coef_a[31]}}, coef_a};
            v <= v + {{(UV_W-32){coef_b[31]}}, coef_b};
            state <= (remaining == 7'd1) ? ST_IDLE : ST_COORD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/ats_checker.sv
`default_nettype none
`include "affine_texture_sampler_macros.svh"
module ats_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        func,
  input wire [6:0]  span_length,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] pixel_value,
  input wire        last_in_span
);

  `ATS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_value) && $stable(last_in_span))
  `ATS_ASSERT_ALWAYS(a_reset_quiet, rst, !out_valid)
  `ATS_ASSERT_NOW(a_span_blocks_input, out_valid && !last_in_span, !in_ready)
  `ATS_ASSERT_NEXT(a_span_busy, in_valid && in_ready && func && span_length != 7'd0, !in_ready)

endmodule

bind affine_texture_sampler ats_checker u_ats_checker (.*);
`default_nettype wire

FILE: verif/affine_texture_sampler_tb.sv
`timescale 1ns / 1ps
module affine_texture_sampler_tb;
  import ats_pkg::*;

  typedef struct {
    logic        f;
    logic [11:0] x;
    logic [11:0] y;
    logic [6:0]  len;
    logic [31:0] tex;
  } pixel_op_t;

  typedef struct {
    logic [31:0] pix;
    logic        last;
  } shaded_pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = FUNC_WRITE;
  logic [11:0] pos_x = '0;
  logic [11:0] pos_y = '0;
  logic [6:0] span_length = '0;
  logic [31:0] texel_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] pixel_value;
  logic last_in_span;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  affine_texture_sampler dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .pos_x(pos_x), .pos_y(pos_y),
    .span_length(span_length), .texel_value(texel_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_value(pixel_value), .last_in_span(last_in_span),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the block state
  logic [31:0] texel_mem [0:65535];
  bit texel_planned [0:65535];
  longint coef [0:5];
  logic [1:0] wrap_mode;
  logic [15:0] tex_size;

  pixel_op_t pending_ops[$];
  pixel_op_t cur_op;
  shaded_pixel_t expected_pixels[$];
  int mismatches = 0;
  int hold_reqs = 0;

  function automatic longint wrap_coord(longint c, longint size);
    longint m;
    if (wrap_mode == MODE_REPEAT) begin
      m = c % size;
      if (m < 0) m += size;
      return m;
    end
    if (wrap_mode == MODE_MIRROR) begin
      m = c % (2 * size);
      if (m < 0) m += 2 * size;
      if (m >= size) m = 2 * size - m - 1;
      return m;
    end
    if (c < 0) return 0;
    if (c > size - 1) return size - 1;
    return c;
  endfunction

  function automatic longint sat_coord(longint c);
    if (c > 64'sd2147483647) return 64'sd2147483647;
    if (c < -64'sd2147483648) return -64'sd2147483648;
    return c;
  endfunction

  function automatic void span_texels(input pixel_op_t op, ref int idx[$]);
    longint w, h, px, py, u, v, tx, ty;
    int n;
    idx.delete();
    w = longint'(tex_size[7:0]) + 1;
    h = longint'(tex_size[15:8]) + 1;
    n = (op.len > 64) ? 64 : int'(op.len);
    px = longint'(op.x) * 65536 + 32768;
    py = longint'(op.y) * 65536 + 32768;
    u = ((coef[0] * px) >>> 16) + ((coef[2] * py) >>> 16) + coef[4];
    v = ((coef[1] * px) >>> 16) + ((coef[3] * py) >>> 16) + coef[5];
    for (int i = 0; i < n; i++) begin
      tx = wrap_coord(sat_coord(u >>> 16), w);
      ty = wrap_coord(sat_coord(v >>> 16), h);
      idx.push_back(int'(ty * 256 + tx));
      u += coef[0];
      v += coef[1];
    end
  endfunction

  function automatic void predict_op(input pixel_op_t op);
    int idx[$];
    shaded_pixel_t e;
    if (op.f == FUNC_WRITE) begin
      if (op.x < 256 && op.y < 256) texel_mem[op.y * 256 + op.x] = op.tex;
      return;
    end
    span_texels(op, idx);
    foreach (idx[i]) begin
      e.pix = texel_mem[idx[i]];
      e.last = (i == idx.size() - 1);
      expected_pixels.push_back(e);
    end
  endfunction

  // queue a span, preceded by writes of any texel it reads that is not yet written
  task automatic add_span(input logic [11:0] x, input logic [11:0] y, input logic [6:0] len);
    pixel_op_t op;
    pixel_op_t wr;
    int idx[$];
    op = '{FUNC_SPAN, x, y, len, $urandom};
    span_texels(op, idx);
    foreach (idx[i]) begin
      if (!texel_planned[idx[i]]) begin
        texel_planned[idx[i]] = 1'b1;
        wr = '{FUNC_WRITE, 12'(idx[i] % 256), 12'(idx[i] / 256), 7'($urandom), $urandom};
        pending_ops.push_back(wr);
      end
    end
    pending_ops.push_back(op);
  endtask

  task automatic add_write(input logic [11:0] x, input logic [11:0] y, input logic [31:0] t);
    pixel_op_t op;
    op = '{FUNC_WRITE, x, y, 7'($urandom), t};
    if (x < 256 && y < 256) texel_planned[y * 256 + x] = 1'b1;
    pending_ops.push_back(op);
  endtask

  task automatic cfg_write(input logic [2:0] r, input logic [31:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (r)
      REG_TILE: wrap_mode = d[1:0];
      REG_SIZE: tex_size = d[15:0];
      default: coef[r] = longint'($signed(d));
    endcase
  endtask

  task automatic set_all(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
                         input logic [31:0] d, input logic [31:0] e, input logic [31:0] f,
                         input logic [1:0] m, input logic [15:0] s);
    cfg_write(REG_COEF_A, a);
    cfg_write(REG_COEF_B, b);
    cfg_write(REG_COEF_C, c);
    cfg_write(REG_COEF_D, d);
    cfg_write(REG_COEF_E, e);
    cfg_write(REG_COEF_F, f);
    cfg_write(REG_TILE, {30'd0, m});
    cfg_write(REG_SIZE, {16'd0, s});
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h60000)) - 32'sh30000);
      2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      3: return 32'($signed($urandom_range(0, 4)) - 2) << 16;
      default: return 32'($urandom_range(0, 32'h3FFFF));
    endcase
  endfunction

  // sender: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_op(cur_op);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          cur_op = pending_ops.pop_front();
          in_valid <= 1'b1;
          func <= cur_op.f;
          pos_x <= cur_op.x;
          pos_y <= cur_op.y;
          span_length <= cur_op.len;
          texel_value <= cur_op.tex;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern, long hold on request, result checking
  logic [15:0] stall_pat = 16'hFFFF;
  int pat_age = 0;
  int hold_cnt = 0;
  int hold_done = 0;
  always @(posedge clk) begin
    shaded_pixel_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected pixel %h last %b", pixel_value, last_in_span);
        end else begin
          e = expected_pixels.pop_front();
          if (pixel_value !== e.pix || last_in_span !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel mismatch: expected %h last %b, got %h last %b",
                       e.pix, e.last, pixel_value, last_in_span);
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else if (hold_done != hold_reqs) begin
        hold_done <= hold_done + 1;
        hold_cnt <= 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= stall_pat[pat_age % 16];
        pat_age <= pat_age + 1;
        if (pat_age % 64 == 63)
          stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      end
    end
  end

  // watchdog on cycles with no transaction
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    coef[0] = 65536; coef[1] = 0; coef[2] = 0;
    coef[3] = 65536; coef[4] = 0; coef[5] = 0;
    wrap_mode = MODE_CLAMP;
    tex_size = 16'hFFFF;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset: identity, clamp, full texture
    add_write(12'd0, 12'd0, 32'h00000000);
    add_write(12'd1, 12'd0, 32'hFFFFFFFF);
    add_write(12'd4095, 12'd4095, 32'hDEADBEEF);
    add_write(12'd10, 12'd300, 32'h12345678);
    add_span(12'd0, 12'd0, 7'd1);
    add_span(12'd0, 12'd0, 7'd0);
    add_span(12'd200, 12'd5, 7'd64);
    add_span(12'd4095, 12'd4095, 7'd3);
    add_span(12'd2730, 12'd1365, 7'd127);
    hold_reqs++;
    drain();

    set_all(32'h7FFFFFFF, 32'h80000000, 32'h00018000, 32'hFFFF0000,
            32'h80000000, 32'h7FFFFFFF, MODE_REPEAT, 16'h0202);
    add_span(12'd3, 12'd7, 7'd20);
    add_span(12'd4095, 12'd0, 7'd5);
    drain();
    set_all(32'hFFFE8000, 32'h00008000, 32'h00000000, 32'h00020000,
            32'hFFF00000, 32'h00000000, MODE_MIRROR, 16'h0304);
    add_span(12'd0, 12'd0, 7'd40);
    add_span(12'd77, 12'd2, 7'd64);
    drain();
    set_all(32'h00030000, 32'hFFFD0000, 32'h80000000, 32'h7FFFFFFF,
            32'h00000000, 32'h00000000, 2'd3, 16'h0000);
    add_span(12'd5, 12'd5, 7'd30);
    add_span(12'd1, 12'd4095, 7'd4);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_all(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
              2'($urandom_range(0, 3)),
              ($urandom_range(0, 5) == 0) ? 16'($urandom) :
              {4'd0, 4'($urandom), 4'd0, 4'($urandom)});
      if (ph == 3) hold_reqs++;
      for (int k = 0; k < 10; k++) begin
        if ($urandom_range(0, 9) < 3) begin
          if ($urandom_range(0, 9) == 0)
            add_write(12'($urandom), 12'($urandom), $urandom);
          else
            add_write(12'($urandom_range(0, 255)), 12'($urandom_range(0, 255)), $urandom);
        end else begin
          add_span(($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40)),
                   ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40)),
                   ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 16)));
        end
        if (ph == 5 && k == 5) drain();
      end
      drain();
    end

    while (pending_ops.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
